// File: rtl/fully_associative_shift_cache_unit_assert.svh
// Assertion macros shared by the cache checker.
`ifndef FULLY_ASSOCIATIVE_SHIFT_CACHE_UNIT_ASSERT_SVH
`define FULLY_ASSOCIATIVE_SHIFT_CACHE_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define FASC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Implication whose consequent must hold in the cycle after its trigger.
`define FASC_ASSERT_NEXT(lbl, trig, cons, msg) \
   `FASC_ASSERT(lbl, (trig) |=> (cons), msg)

`endif

// File: rtl/fasc_pkg.sv
// Types, constants and a helper function of the fully associative shift cache.
package fasc_pkg;

   localparam int ADDR_W   = 32;
   localparam int LINE_W   = 32;
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 2;
   localparam int TAG_W    = ADDR_W - OFFSET_W;
   localparam int COUNT_W  = 32;

   // One cache entry as it moves along the chain.
   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [LINE_W-1:0]  line;
   } entry_type;

   // Request held stable during a lookup.
   typedef struct packed {
      logic [TAG_W-1:0]    tag;
      logic [OFFSET_W-1:0] offset;
      logic [LINE_W-1:0]   fill;
   } query_type;

   // Lookup result carried from cell to cell.
   typedef struct packed {
      logic              found;
      logic [BYTE_W-1:0] data;
   } scan_type;

   // Select one byte of a line by its offset.
   function automatic logic [BYTE_W-1:0] pick_byte(input logic [LINE_W-1:0] line,
                                                   input logic [OFFSET_W-1:0] offset);
      logic [BYTE_W-1:0] result;
      unique case (offset)
         2'd0:    result = line[7:0];
         2'd1:    result = line[15:8];
         2'd2:    result = line[23:16];
         default: result = line[31:24];
      endcase
      return result;
   endfunction

endpackage

// File: rtl/fasc_req_if.sv
// Request channel: byte address and the memory line that holds it.
interface fasc_req_if;
   logic                            valid;
   logic                            ready;
   logic [fasc_pkg::ADDR_W-1:0]     address;
   logic [fasc_pkg::LINE_W-1:0]     fill_line;

   modport source (output valid, output address, output fill_line, input ready);
   modport sink   (input valid, input address, input fill_line, output ready);
endinterface

// File: rtl/fasc_rsp_if.sv
// Response channel: hit flag, read byte and running counters.
interface fasc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            hit;
   logic [fasc_pkg::BYTE_W-1:0]     read_byte;
   logic [fasc_pkg::COUNT_W-1:0]    hits_so_far;
   logic [fasc_pkg::COUNT_W-1:0]    misses_so_far;

   modport source (output valid, output hit, output read_byte, output hits_so_far,
                   output misses_so_far, input ready);
   modport sink   (input valid, input hit, input read_byte, input hits_so_far,
                   input misses_so_far, output ready);
endinterface

// File: rtl/fasc_cell.sv
// One cache entry of the chain with its local compare and result stage.
module fasc_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  fasc_pkg::entry_type  up_entry,
   input  fasc_pkg::query_type  query,
   input  fasc_pkg::scan_type   scan_in,
   output fasc_pkg::entry_type  entry,
   output fasc_pkg::scan_type   scan_out
);

   logic                          valid_ff;
   logic [fasc_pkg::TAG_W-1:0]    tag_ff;
   logic [fasc_pkg::LINE_W-1:0]   line_ff;
   logic                          match;
   fasc_pkg::scan_type            scan_out_in;
   fasc_pkg::scan_type            scan_out_ff;

   // Valid bit is cleared by reset; an invalid entry never matches.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= up_entry.valid;
      end
   end

   // Tag and line move down one place on a miss.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         tag_ff  <= up_entry.tag;
         line_ff <= up_entry.line;
      end
   end

   // An earlier (newer) match has priority over this entry.
   assign match = valid_ff && (tag_ff == query.tag);

   always_comb begin
      scan_out_in = scan_in;
      if (!scan_in.found && match) begin
         scan_out_in.found = 1'b1;
         scan_out_in.data  = fasc_pkg::pick_byte(line_ff, query.offset);
      end
   end

   // Result stage hands the partial lookup result to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_out_ff <= '0;
      end else begin
         scan_out_ff <= scan_out_in;
      end
   end

   assign entry    = '{valid: valid_ff, tag: tag_ff, line: line_ff};
   assign scan_out = scan_out_ff;

endmodule

// File: rtl/fasc_ctrl.sv
// Sequencer: holds the request, times the lookup, updates counters, drives the response.
module fasc_ctrl #(
   parameter int LINES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   fasc_req_if.sink             req_chan,
   fasc_rsp_if.source           rsp_chan,
   input  fasc_pkg::scan_type   scan_result,
   output fasc_pkg::query_type  query,
   output logic                 shift_en
);

   localparam int CNT_W = (LINES > 1) ? $clog2(LINES) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   fasc_pkg::query_type             query_ff;
   logic                            req_xfer;
   logic                            finish_go;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_hit_ff;
   logic [fasc_pkg::BYTE_W-1:0]     rsp_byte_ff;
   logic [fasc_pkg::COUNT_W-1:0]    rsp_hits_ff, rsp_misses_ff;
   logic [fasc_pkg::COUNT_W-1:0]    hit_total_ff, hit_total_in;
   logic [fasc_pkg::COUNT_W-1:0]    miss_total_ff, miss_total_in;
   logic [fasc_pkg::BYTE_W-1:0]     result_byte;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // The result leaves once the output register is free or being emptied.
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);
   assign shift_en  = finish_go && !scan_result.found;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_xfer) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (cnt_ff == CNT_W'(LINES - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Request is captured on transfer and held through the lookup.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         query_ff.tag    <= req_chan.address[fasc_pkg::ADDR_W-1:fasc_pkg::OFFSET_W];
         query_ff.offset <= req_chan.address[fasc_pkg::OFFSET_W-1:0];
         query_ff.fill   <= req_chan.fill_line;
      end
   end

   assign query = query_ff;

   // Counters and read byte for the finished lookup.
   always_comb begin
      hit_total_in  = hit_total_ff;
      miss_total_in = miss_total_ff;
      if (scan_result.found) begin
         hit_total_in = hit_total_ff + fasc_pkg::COUNT_W'(1);
         result_byte  = scan_result.data;
      end else begin
         miss_total_in = miss_total_ff + fasc_pkg::COUNT_W'(1);
         result_byte   = fasc_pkg::pick_byte(query_ff.fill, query_ff.offset);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_total_ff  <= '0;
         miss_total_ff <= '0;
      end else if (finish_go) begin
         hit_total_ff  <= hit_total_in;
         miss_total_ff <= miss_total_in;
      end
   end

   // Output register decouples the receiver from the lookup.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_hit_ff    <= scan_result.found;
         rsp_byte_ff   <= result_byte;
         rsp_hits_ff   <= hit_total_in;
         rsp_misses_ff <= miss_total_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit           = rsp_hit_ff;
   assign rsp_chan.read_byte     = rsp_byte_ff;
   assign rsp_chan.hits_so_far   = rsp_hits_ff;
   assign rsp_chan.misses_so_far = rsp_misses_ff;

endmodule

// File: rtl/fully_associative_shift_cache_unit.sv
// Fully associative cache of 4-byte lines with first-in first-out replacement.
//
// Channels: req_chan carries a byte address and the memory line holding it;
// rsp_chan returns the hit flag, the addressed byte and the running hit and
// miss counts, one response per request.
// Each entry sits in a cell of a chain. The lookup result travels down the
// chain one cell per cycle, passing the result register of every cell. A new
// request is taken only while the sequencer is idle, so the block takes no
// new request before the lookup of the last one has finished.
// On a miss all entries shift down one cell at once, the oldest
// entry drops off the end and the new line enters the first cell.
// Reset (synchronous) invalidates all entries and clears both counters; no
// clearing pass is needed.
// A finished response waits in an output register while rsp_chan.ready is
// low; the next request is still taken and its lookup runs, and it completes
// only once the waiting response has been transferred.
module fully_associative_shift_cache_unit #(
   parameter int LINES = 16
) (
   input  logic         clock,
   input  logic         reset,
   fasc_req_if.sink     req_chan,
   fasc_rsp_if.source   rsp_chan
);

   fasc_pkg::query_type  query;
   logic                 shift_en;
   fasc_pkg::entry_type  entries [LINES];
   fasc_pkg::scan_type   scans   [LINES];
   fasc_pkg::entry_type  head_entry;

   // New line that enters the top of the chain on a miss.
   assign head_entry = '{valid: 1'b1, tag: query.tag, line: query.fill};

   fasc_ctrl #(
      .LINES (LINES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .scan_result (scans[LINES-1]),
      .query       (query),
      .shift_en    (shift_en)
   );

   // Chain of entry cells.
   for (genvar i = 0; i < LINES; i++) begin : g_cell
      if (i == 0) begin : g_head
         fasc_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .up_entry (head_entry),
            .query    (query),
            .scan_in  ('0),
            .entry    (entries[i]),
            .scan_out (scans[i])
         );
      end else begin : g_body
         fasc_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .up_entry (entries[i-1]),
            .query    (query),
            .scan_in  (scans[i-1]),
            .entry    (entries[i]),
            .scan_out (scans[i])
         );
      end
   end

endmodule

// File: rtl/fasc_checker.sv
// Port-level checker for the cache and its bind to the top level.
`include "fully_associative_shift_cache_unit_assert.svh"

module fasc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_hit,
   input  logic [fasc_pkg::BYTE_W-1:0]     rsp_read_byte,
   input  logic [fasc_pkg::COUNT_W-1:0]    rsp_hits_so_far,
   input  logic [fasc_pkg::COUNT_W-1:0]    rsp_misses_so_far
);

   logic                                           rsp_stall;
   logic                                           req_xfer;
   logic [fasc_pkg::BYTE_W+2*fasc_pkg::COUNT_W:0]  rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign req_xfer    = req_valid && req_ready;
   assign rsp_payload = {rsp_hit, rsp_read_byte, rsp_hits_so_far, rsp_misses_so_far};

   // A stalled response stays offered.
   `FASC_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid, "response dropped while stalled")

   // A stalled response keeps its payload.
   `FASC_ASSERT_NEXT(a_rsp_stable, rsp_stall, $stable(rsp_payload), "response changed while stalled")

   // The block is busy in the cycle after taking a request.
   `FASC_ASSERT_NEXT(a_busy_after_req, req_xfer, !req_ready, "request taken during lookup")

   // A new response appears only as the sequencer returns to idle.
   `FASC_ASSERT(a_rsp_with_idle, $rose(rsp_valid) |-> req_ready, "response without idle")

endmodule

bind fully_associative_shift_cache_unit fasc_checker u_fasc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_hit           (rsp_chan.hit),
   .rsp_read_byte     (rsp_chan.read_byte),
   .rsp_hits_so_far   (rsp_chan.hits_so_far),
   .rsp_misses_so_far (rsp_chan.misses_so_far)
);
